FILE: sv/llt_pkg.sv
// Shared constants, types and character helpers of the lookahead lexer tokenizer.
package llt_pkg;

	// Longest token the buffer takes is MAX_TOKEN_LEN-1 characters.
	localparam int unsigned MAX_TOKEN_LEN = 32;
	localparam int unsigned LEN_W         = $clog2(MAX_TOKEN_LEN);
	localparam int unsigned RING_AW       = LEN_W + 1;
	localparam int unsigned RING_DEPTH    = 2 ** RING_AW;
	localparam int unsigned FIFO_DEPTH    = 4;
	localparam int unsigned FIFO_AW       = $clog2(FIFO_DEPTH);

	localparam int unsigned TYPE_W   = 5;
	localparam int unsigned NWORDS   = 23;
	localparam int unsigned WORD_MAX = 6;

	localparam logic [TYPE_W-1:0] T_INTEGER = 5'd23;
	localparam logic [TYPE_W-1:0] T_NAME    = 5'd24;
	localparam logic [TYPE_W-1:0] T_UNKNOWN = 5'd25;

	localparam logic [7:0] CH_EQ = "=";
	localparam logic [7:0] CH_US = "_";

	// Fixed spellings, right-aligned in 48 bits; the index is the token type.
	localparam logic [WORD_MAX*8-1:0] WORD_TEXT [NWORDS] = '{
		"(", ")", "{", "}", "[", "]", ";", ",",
		"exit", "fn", "return", "if", "else", "int", "float", "char",
		"+", "-", "*", "/", " ", "=", "=="
	};
	localparam logic [2:0] WORD_LEN [NWORDS] = '{
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
		3'd4, 3'd2, 3'd6, 3'd2, 3'd4, 3'd3, 3'd5, 3'd4,
		3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2
	};

	typedef enum logic [1:0] {
		ERR_NONE             = 2'd0,
		ERR_UNDERSCORE       = 2'd1,
		ERR_LETTER_AFTER_NUM = 2'd2,
		ERR_TOO_LONG         = 2'd3
	} llt_err_t;

	// One closed token (or one error) handed from the front to the back.
	typedef struct packed {
		llt_err_t          err;
		logic [TYPE_W-1:0] ttype;
		logic [LEN_W-1:0]  len;
	} llt_desc_t;

	typedef struct packed {
		logic      push;
		llt_desc_t desc;
	} llt_push_t;

	typedef struct packed {
		logic               we;
		logic [RING_AW-1:0] addr;
		logic [7:0]         data;
	} llt_wr_t;

	typedef struct packed {
		logic               re;
		logic [RING_AW-1:0] addr;
	} llt_rd_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_decimal(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_sym(input logic [7:0] c);
		logic hit;
		case (c) inside
			"(", ")", "{", "}", "[", "]", ";", ",", "+", "-", "*", "/", " ": hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// True when word k is long enough to have a character at pos and that character is c.
	function automatic logic word_char_ok(input int unsigned k, input logic [LEN_W-1:0] pos,
			input logic [7:0] c);
		logic [2:0] l;
		logic [2:0] sel;
		logic       ok;
		l = WORD_LEN[k];
		if (pos >= LEN_W'(l)) begin
			ok = 1'b0;
		end else begin
			sel = l - 3'd1 - pos[2:0];
			ok  = WORD_TEXT[k][{sel, 3'b000} +: 8] == c;
		end
		return ok;
	endfunction

endpackage

FILE: sv/llt_if.sv
// Handshake channels of the tokenizer: source characters in, token characters out.
interface llt_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] current_char;
	logic [7:0] next_char;
	logic       next_is_end;

	modport source (output valid, current_char, next_char, next_is_end, input ready);
	modport sink (input valid, current_char, next_char, next_is_end, output ready);
endinterface

interface llt_token_if;
	logic       valid;
	logic       ready;
	logic [7:0] token_char;
	logic [4:0] token_type;
	logic       last_of_token;
	logic [1:0] error_code;

	modport source (output valid, token_char, token_type, last_of_token, error_code, input ready);
	modport sink (input valid, token_char, token_type, last_of_token, error_code, output ready);
endinterface

FILE: sv/llt_ram.sv
// Generic simple dual-port RAM with registered read data.
module llt_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: sv/llt_front.sv
// Front part: takes characters, appends them to the ring, closes and classifies tokens.
module llt_front
	import llt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	llt_char_if.sink             char_in,
	input  logic                 fifo_full,
	input  logic [RING_AW:0]     rd_ptr,
	output llt_push_t            push,
	output llt_wr_t              ram_wr
);

	logic [LEN_W-1:0]   len_q;
	logic [RING_AW:0]   wr_q;
	logic [RING_AW:0]   start_q;
	logic               stopped_q;
	logic               first_letter_q;
	logic               first_digit_q;
	logic [NWORDS-1:0]  match_q;

	logic               acc;
	logic [7:0]         c;
	logic [7:0]         n;
	logic               eoi;
	logic               n_eq, n_us, n_dig, n_aln;
	logic               app;
	logic               cls;
	llt_err_t           err;
	logic [LEN_W-1:0]   len_new;
	logic               emit;
	logic               first_letter_new;
	logic               first_digit_new;
	logic [NWORDS-1:0]  match_new;
	logic [TYPE_W-1:0]  ttype;
	logic [RING_AW:0]   wr_next;
	logic [RING_AW:0]   used;

	assign used          = wr_q - rd_ptr;
	assign char_in.ready = stopped_q || (!fifo_full && !used[RING_AW]);
	assign acc           = char_in.valid && char_in.ready;

	assign c     = char_in.current_char;
	assign n     = char_in.next_char;
	assign eoi   = char_in.next_is_end;
	assign n_eq  = !eoi && n == CH_EQ;
	assign n_us  = !eoi && n == CH_US;
	assign n_dig = !eoi && is_decimal(n);
	assign n_aln = !eoi && (is_decimal(n) || is_letter(n));

	always_comb begin
		app = 1'b0;
		cls = 1'b0;
		err = ERR_NONE;
		if (is_sym(c)) begin
			app = 1'b1;
			cls = 1'b1;
		end else if (c == CH_EQ) begin
			app = 1'b1;
			cls = (len_q != '0) || !n_eq;
		end else if (c == CH_US) begin
			if (len_q == '0) begin
				err = ERR_UNDERSCORE;
			end else if (first_letter_q) begin
				app = 1'b1;
				cls = !n_aln && !n_us;
			end else if (first_digit_q) begin
				// Digit separators are dropped from integers.
				cls = !n_dig && !n_us;
			end
		end else if (is_letter(c)) begin
			if (len_q != '0 && !first_letter_q) begin
				err = ERR_LETTER_AFTER_NUM;
			end else begin
				app = 1'b1;
				cls = !n_aln && !n_us;
			end
		end else if (is_decimal(c)) begin
			app = 1'b1;
			if (len_q == '0 || first_digit_q) begin
				cls = !n_dig && !n_us;
			end else if (first_letter_q) begin
				cls = !n_aln && !n_us;
			end
		end

		len_new = len_q + LEN_W'(app);
		if (err == ERR_NONE && !cls && len_new == LEN_W'(MAX_TOKEN_LEN - 1)) begin
			err = ERR_TOO_LONG;
		end
		emit = (err == ERR_NONE) && (cls || eoi) && (len_new != '0);
	end

	assign first_letter_new = (len_q == '0) ? is_letter(c) : first_letter_q;
	assign first_digit_new  = (len_q == '0) ? is_decimal(c) : first_digit_q;

	// Each spelling is tracked one character at a time as the token grows.
	always_comb begin
		for (int unsigned k = 0; k < NWORDS; k++) begin
			match_new[k] = (len_q == '0) || match_q[k];
			if (app) begin
				match_new[k] = match_new[k] && word_char_ok(k, len_q, c);
			end
		end
	end

	always_comb begin
		if (first_digit_new) begin
			ttype = T_INTEGER;
		end else if (first_letter_new) begin
			ttype = T_NAME;
		end else begin
			ttype = T_UNKNOWN;
		end
		for (int k = NWORDS - 1; k >= 0; k--) begin
			if (match_new[k] && LEN_W'(WORD_LEN[k]) == len_new) begin
				ttype = TYPE_W'(k);
			end
		end
	end

	assign wr_next = wr_q + (RING_AW + 1)'(app);

	always_comb begin
		push.push       = acc && !stopped_q && (err != ERR_NONE || emit);
		push.desc.err   = err;
		push.desc.ttype = (err != ERR_NONE) ? T_UNKNOWN : ttype;
		push.desc.len   = len_new;
		ram_wr.we       = acc && !stopped_q && app && err == ERR_NONE;
		ram_wr.addr     = wr_q[RING_AW-1:0];
		ram_wr.data     = c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q          <= '0;
			wr_q           <= '0;
			start_q        <= '0;
			stopped_q      <= 1'b0;
			first_letter_q <= 1'b0;
			first_digit_q  <= 1'b0;
			match_q        <= '0;
		end else if (acc && !stopped_q) begin
			first_letter_q <= first_letter_new;
			first_digit_q  <= first_digit_new;
			match_q        <= match_new;
			if (err != ERR_NONE) begin
				// Drop the open token and stop until reset.
				stopped_q <= 1'b1;
				len_q     <= '0;
				wr_q      <= start_q;
			end else if (emit) begin
				len_q   <= '0;
				wr_q    <= wr_next;
				start_q <= wr_next;
			end else begin
				len_q <= len_new;
				wr_q  <= wr_next;
			end
		end
	end

endmodule

FILE: sv/llt_fifo.sv
// Short queue of closed-token descriptors between the front and the back.
module llt_fifo
	import llt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  llt_push_t push,
	input  logic      pop,
	output logic      full,
	output logic      empty,
	output llt_desc_t head
);

	llt_desc_t          entry_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;

	assign full  = cnt_q == (FIFO_AW + 1)'(FIFO_DEPTH);
	assign empty = cnt_q == '0;
	assign head  = entry_q[rd_q];

	always_ff @(posedge clk) begin
		if (push.push) begin
			entry_q[wr_q] <= push.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.push) begin
				wr_q <= wr_q + FIFO_AW'(1);
			end
			if (pop) begin
				rd_q <= rd_q + FIFO_AW'(1);
			end
			cnt_q <= cnt_q + (FIFO_AW + 1)'(push.push) - (FIFO_AW + 1)'(pop);
		end
	end

endmodule

FILE: sv/llt_back.sv
// Back part: walks queued tokens through the ring and emits one character per beat.
module llt_back
	import llt_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fifo_empty,
	input  llt_desc_t        fifo_head,
	output logic             fifo_pop,
	output logic [RING_AW:0] rd_ptr,
	output llt_rd_t          ram_rd,
	input  logic [7:0]       ram_rdata,
	llt_token_if.source      token_out
);

	logic                out_valid_q;
	logic [TYPE_W-1:0]   ttype_q;
	logic                last_q;
	llt_err_t            err_q;
	logic [RING_AW:0]    rd_q;
	logic [LEN_W-1:0]    idx_q;

	logic                adv;
	logic                head_err;
	logic                last_char;

	assign head_err  = fifo_head.err != ERR_NONE;
	assign adv       = (!out_valid_q || token_out.ready) && !fifo_empty;
	assign last_char = (idx_q + LEN_W'(1)) == fifo_head.len;
	assign fifo_pop  = adv && (head_err || last_char);
	assign rd_ptr    = rd_q;

	always_comb begin
		ram_rd.re   = adv && !head_err;
		ram_rd.addr = rd_q[RING_AW-1:0];
	end

	// The RAM read register serves as the character part of the output register.
	assign token_out.valid         = out_valid_q;
	assign token_out.token_char    = (err_q != ERR_NONE) ? 8'h00 : ram_rdata;
	assign token_out.token_type    = ttype_q;
	assign token_out.last_of_token = last_q;
	assign token_out.error_code    = err_q;

	always_ff @(posedge clk) begin
		if (adv) begin
			ttype_q <= fifo_head.ttype;
			last_q  <= head_err || last_char;
			err_q   <= fifo_head.err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rd_q        <= '0;
			idx_q       <= '0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			if (!head_err) begin
				rd_q <= rd_q + (RING_AW + 1)'(1);
			end
			idx_q <= fifo_pop ? '0 : idx_q + LEN_W'(1);
		end else if (token_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: sv/lookahead_lexer_tokenizer.sv
// Top level of the lookahead lexer tokenizer: front, descriptor queue, character ring, back.
//
// The block takes one source character per beat together with its lookahead and returns
// each finished token as a run of beats, one per character, all carrying the token type
// and with last_of_token set on the final character. The front takes a character in every
// cycle while there is room: each character is written into a 64-entry character ring
// and a token's type is worked out as it grows, by tracking which fixed spellings still
// agree with it. When the lookahead cannot extend a token, or the input ends, the front
// places a descriptor (type and length) into a four-entry queue and goes on with the next
// token at once. The back reads the ring one entry per cycle while a descriptor waits and
// the output side takes a beat every cycle, and goes on to the next token without a gap;
// the sustained rate is one character in and one out per cycle, set by the single read
// port of the ring. The front holds off input when the ring or the descriptor queue is
// full. A leading underscore, a letter after a number, or a token reaching 31 characters
// without being closed by the lookahead gives one error beat (character zero, type unknown,
// last_of_token set, the error code); the open token is dropped, tokens closed before it
// are still delivered, and from then on every input beat is taken and ignored until reset.
module lookahead_lexer_tokenizer
	import llt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	llt_char_if.sink    char_in,
	llt_token_if.source token_out
);

	llt_push_t        push;
	llt_wr_t          ram_wr;
	llt_rd_t          ram_rd;
	logic [7:0]       ram_rdata;
	logic             fifo_full;
	logic             fifo_empty;
	logic             fifo_pop;
	llt_desc_t        fifo_head;
	logic [RING_AW:0] rd_ptr;

	// Front classifies characters and commits whole tokens.
	llt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_in   (char_in),
		.fifo_full (fifo_full),
		.rd_ptr    (rd_ptr),
		.push      (push),
		.ram_wr    (ram_wr)
	);

	// Token descriptors wait here so that each side can stall on its own.
	llt_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (fifo_pop),
		.full   (fifo_full),
		.empty  (fifo_empty),
		.head   (fifo_head)
	);

	// Character ring: the front writes in order, the back reads committed tokens in order.
	llt_ram #(
		.WIDTH (8),
		.DEPTH (RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_wr.we),
		.waddr (ram_wr.addr),
		.wdata (ram_wr.data),
		.re    (ram_rd.re),
		.raddr (ram_rd.addr),
		.rdata (ram_rdata)
	);

	// Back emits the beats of each token.
	llt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.fifo_empty (fifo_empty),
		.fifo_head  (fifo_head),
		.fifo_pop   (fifo_pop),
		.rd_ptr     (rd_ptr),
		.ram_rd     (ram_rd),
		.ram_rdata  (ram_rdata),
		.token_out  (token_out)
	);

endmodule
